// ===== rtl/cdad_pkg.sv =====
package cdad_pkg;

	// Only the low DAYS_WIDTH bits of the day count take part in the walk.
	localparam int DAYS_WIDTH = 16;

	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int YEAR_W  = 14;
	localparam int STAT_W  = 2;
	localparam int MOD_W   = 9;

	localparam logic [YEAR_W-1:0]  YEAR_MIN = YEAR_W'(1800);
	localparam logic [YEAR_W-1:0]  YEAR_MAX = YEAR_W'(10000);
	localparam logic [MONTH_W-1:0] MONTHS   = MONTH_W'(12);

	// Residue of the year modulo 400, found by restoring subtraction.
	localparam int MOD_BASE  = 400;
	localparam int MOD_STEPS = 6;
	localparam logic [YEAR_W-1:0] MOD_TOP = YEAR_W'(MOD_BASE << (MOD_STEPS - 1));

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_DAY   = 2'd2;

	typedef logic [MOD_W-1:0] mod_t;

	function automatic logic is_leap(input mod_t r);
		logic by4;
		logic century;
		by4     = (r[1:0] == 2'd0);
		century = (r == MOD_W'(100)) || (r == MOD_W'(200)) || (r == MOD_W'(300));
		return (by4 && !century) || (r == MOD_W'(0));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                   n = DAY_W'(30);
			4'd2:                                      n = leap ? DAY_W'(29) : DAY_W'(28);
			default:                                   n = DAY_W'(0);
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/calendar_date_add_days.sv =====
// Gregorian date plus a number of days.
//
// Channels: a command word (month_in, day_in, year_in, days_to_add) is taken
// at a rising edge where start is high and busy is low. The result word
// (month_out, day_out, year_out, status) is shown for exactly one cycle with
// done high; the receiver cannot stall it and must take it in that cycle.
//
// Sequence: the command is loaded, the year is reduced modulo 400 by restoring
// steps on the shared compare-and-subtract unit, the start date is checked,
// then the walk advances one month per cycle, the last month included. A full
// 65535-day add walks about 2154 months; a rejected date returns straight after
// the check. busy is high for the whole command and one command is in flight
// at a time.
//
// Status 1 means a field is out of range, status 2 means the day exceeds the
// month; in both cases the date comes back unchanged.
//
// Reset: arst_n clears the sequencer and the done strobe at once; the block
// comes out of reset idle and ready for a command.
module calendar_date_add_days (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [cdad_pkg::MONTH_W-1:0]       month_in,
	input  logic [cdad_pkg::DAY_W-1:0]         day_in,
	input  logic [cdad_pkg::YEAR_W-1:0]        year_in,
	input  logic [cdad_pkg::DAYS_WIDTH-1:0]    days_to_add,
	output logic                               done,
	output logic [cdad_pkg::MONTH_W-1:0]       month_out,
	output logic [cdad_pkg::DAY_W-1:0]         day_out,
	output logic [cdad_pkg::YEAR_W-1:0]        year_out,
	output logic [cdad_pkg::STAT_W-1:0]        status
);
	import cdad_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RED   = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_WALK  = 2'd3;

	logic [1:0]            state_q;
	logic                  done_q;
	logic [2:0]            step_q;
	logic [MONTH_W-1:0]    month_q;
	logic [DAY_W-1:0]      day_q;
	logic [YEAR_W-1:0]     year_q;
	logic [YEAR_W-1:0]     rem_q;
	logic [DAYS_WIDTH-1:0] left_q;
	logic [STAT_W-1:0]     status_q;

	logic [YEAR_W-1:0]     divisor;
	logic                  fits;
	mod_t                  res;
	logic [DAY_W-1:0]      dim;
	logic [DAY_W-1:0]      rest;
	logic                  out_of_range;
	logic                  next_month;

	assign res     = rem_q[MOD_W-1:0];
	assign divisor = MOD_TOP >> step_q;
	assign fits    = (rem_q >= divisor);
	assign dim     = month_days(month_q, is_leap(res));
	assign rest    = dim - day_q;

	assign out_of_range = (month_q < MONTH_W'(1)) || (month_q > MONTHS) ||
		(day_q == DAY_W'(0)) || (year_q < YEAR_MIN) || (year_q > YEAR_MAX);
	assign next_month = (left_q > DAYS_WIDTH'(rest));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (step_q == 3'(MOD_STEPS - 1)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (out_of_range || (day_q > dim)) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!next_month) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					month_q  <= month_in;
					day_q    <= day_in;
					year_q   <= year_in;
					rem_q    <= year_in;
					left_q   <= days_to_add;
					step_q   <= 3'd0;
					status_q <= ST_OK;
				end
			end
			S_RED: begin
				// One restoring step: subtract 400 times a falling power of two.
				if (fits) begin
					rem_q <= rem_q - divisor;
				end
				step_q <= step_q + 3'd1;
			end
			S_CHECK: begin
				if (out_of_range) begin
					status_q <= ST_RANGE;
				end else if (day_q > dim) begin
					status_q <= ST_DAY;
				end
			end
			S_WALK: begin
				if (next_month) begin
					left_q <= left_q - DAYS_WIDTH'(rest) - DAYS_WIDTH'(1);
					day_q  <= DAY_W'(1);
					if (month_q == MONTHS) begin
						month_q <= MONTH_W'(1);
						year_q  <= year_q + YEAR_W'(1);
						// The residue tracks the year so the leap rule holds for every February.
						rem_q   <= (res == mod_t'(MOD_BASE - 1)) ? '0 : rem_q + YEAR_W'(1);
					end else begin
						month_q <= month_q + MONTH_W'(1);
					end
				end else begin
					day_q  <= day_q + left_q[DAY_W-1:0];
					left_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign month_out = month_q;
	assign day_out   = day_q;
	assign year_out  = year_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a command in flight");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted command did not raise busy");

	a_residue_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK || state_q == S_WALK) |-> (rem_q < YEAR_W'(MOD_BASE)))
		else $error("year residue not below 400");

	a_ok_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OK) |-> (month_out >= MONTH_W'(1) &&
		month_out <= MONTHS && day_out >= DAY_W'(1)))
		else $error("ok result holds an invalid date");

	a_walk_day_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (day_q <= dim))
		else $error("walk day beyond month length");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import cdad_pkg::*;

	typedef struct packed {
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [YEAR_W-1:0]  year;
		logic [STAT_W-1:0]  status;
	} date_word_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  start       = 1'b0;
	logic                  busy;
	logic [MONTH_W-1:0]    month_in    = '0;
	logic [DAY_W-1:0]      day_in      = '0;
	logic [YEAR_W-1:0]     year_in     = '0;
	logic [DAYS_WIDTH-1:0] days_to_add = '0;
	logic                  done;
	logic [MONTH_W-1:0]    month_out;
	logic [DAY_W-1:0]      day_out;
	logic [YEAR_W-1:0]     year_out;
	logic [STAT_W-1:0]     status;

	date_word_t pending_dates[$];
	date_word_t wanted_date;
	int         fail_count  = 0;
	bit         steady_feed = 1'b0;

	calendar_date_add_days dut (.*);

	always #1 clk = ~clk;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		int unsigned n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11:           n = 30;
			2:                     n = leap_year(y) ? 29 : 28;
			default:               n = 0;
		endcase
		return n;
	endfunction

	// Walks one month at a time, the same way the hardware is meant to.
	function automatic date_word_t add_days(input logic [MONTH_W-1:0] m_in,
		input logic [DAY_W-1:0] d_in, input logic [YEAR_W-1:0] y_in,
		input logic [DAYS_WIDTH-1:0] count);
		int unsigned m;
		int unsigned d;
		int unsigned y;
		int unsigned left;
		int unsigned rest;
		date_word_t  r;
		m = m_in;
		d = d_in;
		y = y_in;
		left = count;
		r.status = ST_OK;
		if (m < 1 || m > MONTHS || d < 1 || y < YEAR_MIN || y > YEAR_MAX) begin
			r.status = ST_RANGE;
		end else if (d > month_length(m, y)) begin
			r.status = ST_DAY;
		end else begin
			while (left > 0) begin
				rest = month_length(m, y) - d;
				if (left > rest) begin
					left -= rest + 1;
					d = 1;
					if (m == MONTHS) begin
						m = 1;
						y = (y + 1) % (1 << YEAR_W);
					end else begin
						m++;
					end
				end else begin
					d += left;
					left = 0;
				end
			end
		end
		r.month = MONTH_W'(m);
		r.day   = DAY_W'(d);
		r.year  = YEAR_W'(y);
		return r;
	endfunction

	// Start stays high across back-to-back words; send_word only drops it when a gap is drawn.
	task automatic send_word(input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
		input logic [YEAR_W-1:0] y, input logic [DAYS_WIDTH-1:0] count);
		int gap;
		gap = steady_feed ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		month_in    <= m;
		day_in      <= d;
		year_in     <= y;
		days_to_add <= count;
		do @(posedge clk); while (busy);
		pending_dates.push_back(add_days(m, d, y, count));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	task automatic test_bad_fields();
		send_word(4'd0, 5'd1, YEAR_W'(2000), 16'd10);
		send_word(4'd15, 5'd31, YEAR_W'(16383), 16'hFFFF);
		send_word(4'd13, 5'd10, YEAR_W'(2000), 16'd1);
		send_word(4'd5, 5'd0, YEAR_W'(2000), 16'd1);
		send_word(4'd1, 5'd1, YEAR_W'(1799), 16'd1);
		send_word(4'd12, 5'd31, YEAR_W'(10001), 16'd0);
	endtask

	task automatic test_bad_day_of_month();
		send_word(4'd2, 5'd30, YEAR_W'(2000), 16'd5);
		send_word(4'd2, 5'd29, YEAR_W'(2001), 16'd5);
		send_word(4'd2, 5'd29, YEAR_W'(1900), 16'd5);
		send_word(4'd4, 5'd31, YEAR_W'(2000), 16'd5);
	endtask

	task automatic test_date_walks();
		send_word(4'd1, 5'd1, YEAR_W'(1800), 16'd0);
		send_word(4'd7, 5'd15, YEAR_W'(2024), 16'd0);
		send_word(4'd2, 5'd28, YEAR_W'(2000), 16'd1);
		send_word(4'd2, 5'd28, YEAR_W'(1900), 16'd1);
		send_word(4'd2, 5'd29, YEAR_W'(2000), 16'd1);
		send_word(4'd2, 5'd28, YEAR_W'(2400), 16'd366);
		send_word(4'd12, 5'd31, YEAR_W'(1999), 16'd1);
		send_word(4'd1, 5'd31, YEAR_W'(2023), 16'd29);
		send_word(4'd1, 5'd1, YEAR_W'(1800), 16'hFFFF);
		send_word(4'd12, 5'd31, YEAR_W'(10000), 16'hFFFF);
		send_word(4'd3, 5'd1, YEAR_W'(2100), 16'h8000);
		send_word(4'd11, 5'd30, YEAR_W'(9999), 16'h5555);
		send_word(4'd6, 5'd30, YEAR_W'(4000), 16'hAAAA);
	endtask

	// Mostly valid dates with random walks, short counts weighted heavily so the
	// run stays short, plus some raw words over the full field ranges.
	task automatic test_random_dates(input int count);
		logic [MONTH_W-1:0]    m;
		logic [DAY_W-1:0]      d;
		logic [YEAR_W-1:0]     y;
		logic [DAYS_WIDTH-1:0] n;
		int                    pick;
		for (int i = 0; i < count; i++) begin
			if (i % 25 == 0)
				steady_feed = ($urandom_range(0, 2) == 0);
			if (i % 60 == 59)
				wait_drained();
			if ($urandom_range(0, 99) < 15) begin
				m = MONTH_W'($urandom);
				d = DAY_W'($urandom);
				y = YEAR_W'($urandom);
				n = DAYS_WIDTH'($urandom);
			end else begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					y = YEAR_MIN;
				else if (pick == 1)
					y = YEAR_MAX - YEAR_W'($urandom_range(0, 3));
				else
					y = YEAR_W'($urandom_range(YEAR_MIN, YEAR_MAX));
				m = MONTH_W'($urandom_range(1, MONTHS));
				d = DAY_W'($urandom_range(1, month_length(m, y)));
				pick = $urandom_range(0, 99);
				if (pick < 60)
					n = DAYS_WIDTH'($urandom_range(0, 400));
				else if (pick < 85)
					n = DAYS_WIDTH'($urandom_range(0, 5000));
				else
					n = DAYS_WIDTH'($urandom);
			end
			send_word(m, d, y, n);
		end
		steady_feed = 1'b0;
	endtask

	// Outputs are read before the edge updates them, so each word is seen once.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				$error("result word with no command pending: %0d/%0d/%0d status %0d",
					month_out, day_out, year_out, status);
				fail_count++;
			end else begin
				wanted_date = pending_dates.pop_front();
				if (month_out !== wanted_date.month) begin
					$error("month_out: expected %0d, got %0d", wanted_date.month, month_out);
					fail_count++;
				end
				if (day_out !== wanted_date.day) begin
					$error("day_out: expected %0d, got %0d", wanted_date.day, day_out);
					fail_count++;
				end
				if (year_out !== wanted_date.year) begin
					$error("year_out: expected %0d, got %0d", wanted_date.year, year_out);
					fail_count++;
				end
				if (status !== wanted_date.status) begin
					$error("status: expected %0d, got %0d", wanted_date.status, status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("calendar_date_add_days test failed");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_bad_fields();
		test_bad_day_of_month();
		wait_drained();
		test_date_walks();
		test_random_dates(250);
		start <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("calendar_date_add_days test passed");
		else
			$display("calendar_date_add_days test failed");
		$finish;
	end

endmodule
